### rtl/irsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irsa_pkg
// Shared types and constants of the interval resource allocator.
// ----------------------------------------------------------------------------
package irsa_pkg;

  localparam int TIME_BITS   = 16;
  localparam int OUT_W       = 7;
  localparam int MAX_RES_DEF = 64;

  typedef struct packed {
    logic [TIME_BITS-1:0] start_time;
    logic [TIME_BITS-1:0] end_time;
  } irsa_request_t;

  typedef struct packed {
    logic [OUT_W-1:0] resource_id;
    logic [OUT_W-1:0] resources_used;
    logic             overflow;
  } irsa_result_t;

  // Commands from the sequencer to the busy-until table.
  typedef struct packed {
    logic scan_start;
    logic release_en;
    logic write_en;
  } irsa_table_cmd_t;

  // Scan status from the busy-until table.
  typedef struct packed {
    logic done;
    logic found;
  } irsa_scan_t;

  // Commands from the sequencer to the free list.
  typedef struct packed {
    logic push;
    logic pop;
  } irsa_fifo_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN_START,
    ST_SCAN_WAIT,
    ST_POP_WAIT
  } irsa_state_t;

endpackage

### rtl/irsa_busy_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irsa_busy_table
// Busy-until memory with busy flags and a sequential minimum-search scan.
// ----------------------------------------------------------------------------
module irsa_busy_table
  import irsa_pkg::*;
#(
  parameter int MAX_RES = MAX_RES_DEF,
  parameter int IDX_W   = $clog2(MAX_RES),
  parameter int CNT_W   = $clog2(MAX_RES + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  irsa_table_cmd_t      cmd,
  input  logic [CNT_W-1:0]     limit,
  input  logic [TIME_BITS-1:0] thresh,
  input  logic [IDX_W-1:0]     write_idx,
  input  logic [TIME_BITS-1:0] write_time,
  output irsa_scan_t           status,
  output logic [IDX_W-1:0]     best_idx
);

  logic [TIME_BITS-1:0] mem [MAX_RES];
  logic [MAX_RES-1:0]   is_busy;
  logic                 scanning;
  logic [CNT_W-1:0]     cnt;
  logic                 rd_valid;
  logic [IDX_W-1:0]     rd_idx;
  logic [TIME_BITS-1:0] rd_data;
  logic                 found;
  logic                 done;
  logic [TIME_BITS-1:0] best_val;
  logic                 issue;
  logic                 hit;

  assign issue = scanning && !cmd.scan_start && (cnt != limit);

  // Strict less-than keeps the lower id on equal busy-until times.
  assign hit = rd_valid && is_busy[rd_idx] && (rd_data <= thresh) &&
               (!found || (rd_data < best_val));

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data <= mem[cnt[IDX_W-1:0]];
    end
    if (cmd.write_en) begin
      mem[write_idx] <= write_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scanning <= 1'b0;
      cnt      <= '0;
      rd_valid <= 1'b0;
      found    <= 1'b0;
      done     <= 1'b0;
      is_busy  <= '0;
    end else begin
      done     <= 1'b0;
      rd_valid <= issue;
      if (cmd.scan_start) begin
        scanning <= 1'b1;
        cnt      <= '0;
        found    <= 1'b0;
      end else if (scanning) begin
        if (issue) begin
          cnt <= cnt + CNT_W'(1);
        end else if (!rd_valid) begin
          scanning <= 1'b0;
          done     <= 1'b1;
        end
        if (hit) begin
          found <= 1'b1;
        end
      end
      if (cmd.release_en) begin
        is_busy[best_idx] <= 1'b0;
      end
      if (cmd.write_en) begin
        is_busy[write_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_idx <= cnt[IDX_W-1:0];
    end
    if (hit) begin
      best_idx <= rd_idx;
      best_val <= rd_data;
    end
  end

  assign status.done  = done;
  assign status.found = found;

endmodule

### rtl/irsa_free_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irsa_free_fifo
// Circular free list of released resource ids, held in a memory.
// ----------------------------------------------------------------------------
module irsa_free_fifo
  import irsa_pkg::*;
#(
  parameter int MAX_RES = MAX_RES_DEF,
  parameter int IDX_W   = $clog2(MAX_RES),
  parameter int CNT_W   = $clog2(MAX_RES + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  irsa_fifo_cmd_t   cmd,
  input  logic [CNT_W-1:0] push_id,
  output logic [CNT_W-1:0] pop_id,
  output logic             empty
);

  logic [CNT_W-1:0] mem [MAX_RES];
  logic [IDX_W-1:0] head;
  logic [IDX_W-1:0] head_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W:0]   tail_sum;
  logic [IDX_W-1:0] tail;
  logic             full;
  logic             init0;
  logic             pop_init;
  logic [CNT_W-1:0] rd_data;

  assign full  = (count == CNT_W'(MAX_RES));
  assign empty = (count == '0);

  // head + count stays below twice the depth, so one subtract wraps it.
  always_comb begin
    tail_sum = (CNT_W + 1)'(head) + (CNT_W + 1)'(count);
    if (tail_sum >= (CNT_W + 1)'(MAX_RES)) begin
      tail_sum = tail_sum - (CNT_W + 1)'(MAX_RES);
    end
    tail = tail_sum[IDX_W-1:0];
  end

  assign head_next = (head == IDX_W'(MAX_RES - 1)) ? '0 : head + IDX_W'(1);

  // Entry 0 holds resource 1 after reset; it reads as 1 until it is
  // written or popped, so the memory needs no initial fill.
  assign pop_id = pop_init ? CNT_W'(1) : rd_data;

  always_ff @(posedge clk) begin
    if (cmd.push && !full) begin
      mem[tail] <= push_id;
    end
    if (cmd.pop) begin
      rd_data  <= mem[head];
      pop_init <= init0 && (head == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= CNT_W'(1);
      init0 <= 1'b1;
    end else begin
      if (cmd.push && !full) begin
        count <= count + CNT_W'(1);
        if (tail == '0) begin
          init0 <= 1'b0;
        end
      end else if (cmd.pop) begin
        head  <= head_next;
        count <= count - CNT_W'(1);
        if (head == '0) begin
          init0 <= 1'b0;
        end
      end
    end
  end

endmodule

### rtl/irsa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irsa_ctrl
// Sequencer: release scans, allocation from the free list or a new id.
// ----------------------------------------------------------------------------
module irsa_ctrl
  import irsa_pkg::*;
#(
  parameter int MAX_RES = MAX_RES_DEF,
  parameter int IDX_W   = $clog2(MAX_RES),
  parameter int CNT_W   = $clog2(MAX_RES + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  irsa_request_t        request,
  output logic                 done,
  output irsa_result_t         result,
  output irsa_table_cmd_t      tcmd,
  output logic [CNT_W-1:0]     limit,
  output logic [TIME_BITS-1:0] thresh,
  output logic [IDX_W-1:0]     write_idx,
  output logic [TIME_BITS-1:0] write_time,
  input  irsa_scan_t           scan,
  input  logic [IDX_W-1:0]     best_idx,
  output irsa_fifo_cmd_t       fcmd,
  output logic [CNT_W-1:0]     push_id,
  input  logic [CNT_W-1:0]     pop_id,
  input  logic                 fifo_empty
);

  irsa_state_t          state;
  irsa_state_t          state_next;
  logic [TIME_BITS-1:0] start_time;
  logic [TIME_BITS-1:0] end_time;
  logic [CNT_W-1:0]     opened;
  logic [CNT_W-1:0]     opened_inc;
  logic [CNT_W-1:0]     pop_idx;
  logic                 can_open;

  assign opened_inc = opened + CNT_W'(1);
  assign pop_idx    = pop_id - CNT_W'(1);
  assign can_open   = (opened < CNT_W'(MAX_RES));
  assign busy       = (state != ST_IDLE);
  assign limit      = opened;
  assign thresh     = start_time;
  assign write_time = end_time;
  assign push_id    = CNT_W'(best_idx) + CNT_W'(1);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_SCAN_START;
        end
      end
      ST_SCAN_START: begin
        state_next = ST_SCAN_WAIT;
      end
      ST_SCAN_WAIT: begin
        if (scan.done) begin
          if (scan.found) begin
            state_next = ST_SCAN_START;
          end else if (!fifo_empty) begin
            state_next = ST_POP_WAIT;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_POP_WAIT: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    tcmd      = '0;
    fcmd      = '0;
    write_idx = pop_idx[IDX_W-1:0];
    case (state)
      ST_SCAN_START: begin
        tcmd.scan_start = 1'b1;
      end
      ST_SCAN_WAIT: begin
        if (scan.done) begin
          if (scan.found) begin
            tcmd.release_en = 1'b1;
            fcmd.push       = 1'b1;
          end else if (!fifo_empty) begin
            fcmd.pop = 1'b1;
          end else if (can_open) begin
            // The new id is opened + 1, so its table index is opened.
            tcmd.write_en = 1'b1;
            write_idx     = opened[IDX_W-1:0];
          end
        end
      end
      ST_POP_WAIT: begin
        tcmd.write_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      opened <= CNT_W'(1);
      done   <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (state == ST_SCAN_WAIT && scan.done && !scan.found && fifo_empty) begin
        done <= 1'b1;
        if (can_open) begin
          opened <= opened_inc;
        end
      end
      if (state == ST_POP_WAIT) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      start_time <= request.start_time;
      end_time   <= request.end_time;
    end
    if (state == ST_SCAN_WAIT && scan.done && !scan.found && fifo_empty) begin
      if (can_open) begin
        result.resource_id    <= OUT_W'(opened_inc);
        result.resources_used <= OUT_W'(opened_inc);
        result.overflow       <= 1'b0;
      end else begin
        result.resource_id    <= '0;
        result.resources_used <= OUT_W'(opened);
        result.overflow       <= 1'b1;
      end
    end
    if (state == ST_POP_WAIT) begin
      result.resource_id    <= OUT_W'(pop_id);
      result.resources_used <= OUT_W'(opened);
      result.overflow       <= 1'b0;
    end
  end

endmodule

### rtl/interval_resource_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_resource_allocator_core
// Greedy interval partitioning: assigns each interval a free resource id.
// ----------------------------------------------------------------------------
// A request (start_time, end_time) is taken when start is high and busy is
// low; requests should arrive sorted by start, then by end. Each request
// yields one result (resource_id, resources_used, overflow), shown on result
// for exactly one cycle with done high. The receiver cannot stall, so the
// result must be captured in that cycle.
// Each request first releases every busy resource whose busy-until time is at
// most its start, one release per pass over the busy-until memory, earliest
// time first. When a new id is opened or the table overflows, done rises as
// the last pass ends, and when the id comes from the free list it rises
// after the ST_POP_WAIT state. Each pass reads the busy-until memory once
// per open resource through its single read port. busy stays high from
// acceptance until the cycle done is shown; a new request may be given in
// the cycle of done.
// Synchronous reset leaves no resource busy, resource 1 on the free list and
// one resource counted as open; no clearing pass is needed.
// ----------------------------------------------------------------------------
module interval_resource_allocator_core
  import irsa_pkg::*;
#(
  parameter int MAX_RES = MAX_RES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  irsa_request_t request,
  output logic          done,
  output irsa_result_t  result
);

  localparam int IDX_W = $clog2(MAX_RES);
  localparam int CNT_W = $clog2(MAX_RES + 1);

  irsa_table_cmd_t      tcmd;
  irsa_scan_t           scan;
  irsa_fifo_cmd_t       fcmd;
  logic [CNT_W-1:0]     limit;
  logic [TIME_BITS-1:0] thresh;
  logic [IDX_W-1:0]     write_idx;
  logic [TIME_BITS-1:0] write_time;
  logic [IDX_W-1:0]     best_idx;
  logic [CNT_W-1:0]     push_id;
  logic [CNT_W-1:0]     pop_id;
  logic                 fifo_empty;

  irsa_ctrl #(
    .MAX_RES(MAX_RES),
    .IDX_W  (IDX_W),
    .CNT_W  (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .tcmd      (tcmd),
    .limit     (limit),
    .thresh    (thresh),
    .write_idx (write_idx),
    .write_time(write_time),
    .scan      (scan),
    .best_idx  (best_idx),
    .fcmd      (fcmd),
    .push_id   (push_id),
    .pop_id    (pop_id),
    .fifo_empty(fifo_empty)
  );

  irsa_busy_table #(
    .MAX_RES(MAX_RES),
    .IDX_W  (IDX_W),
    .CNT_W  (CNT_W)
  ) u_table (
    .clk       (clk),
    .rst       (rst),
    .cmd       (tcmd),
    .limit     (limit),
    .thresh    (thresh),
    .write_idx (write_idx),
    .write_time(write_time),
    .status    (scan),
    .best_idx  (best_idx)
  );

  irsa_free_fifo #(
    .MAX_RES(MAX_RES),
    .IDX_W  (IDX_W),
    .CNT_W  (CNT_W)
  ) u_fifo (
    .clk    (clk),
    .rst    (rst),
    .cmd    (fcmd),
    .push_id(push_id),
    .pop_id (pop_id),
    .empty  (fifo_empty)
  );

endmodule

### rtl/irsa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irsa_checker
// Port-level checks of the allocator's request and result timing.
// ----------------------------------------------------------------------------
module irsa_checker
  import irsa_pkg::*;
(
  input logic         clk,
  input logic         rst,
  input logic         start,
  input logic         busy,
  input logic         done,
  input irsa_result_t result
);

  // A result is only shown once the block has gone idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done asserted while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // Every request ends in a result shown as busy drops.
  a_fell_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy dropped without a result");

  a_done_past: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a request in progress");

  a_ovf_id: assert property (@(posedge clk) disable iff (rst)
    (done && result.overflow) |-> (result.resource_id == '0))
    else $error("overflow result carries a nonzero id");

endmodule

bind interval_resource_allocator_core irsa_checker u_irsa_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .result(result)
);

### tb/tb_interval_resource_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_interval_resource_allocator_core
// Self-checking testbench of the greedy interval resource allocator.
// ----------------------------------------------------------------------------
// Requests are sent through the start/busy handshake. A behavioral allocator
// in the testbench mirrors the busy-until table, the free list and the open
// count. Each result strobed on done is compared with the oldest allocation
// that this allocator predicts. The run starts with directed corner cases. It
// then sends sorted epochs of random intervals with random idle gaps, and ends
// with a full overflow and a release of every resource at once.
// ----------------------------------------------------------------------------
module tb_interval_resource_allocator_core;
  import irsa_pkg::*;

  localparam int NUM_RES      = MAX_RES_DEF;
  localparam int RANDOM_ITEMS = 1700;
  localparam int STALL_LIMIT  = 20000;
  localparam int TAIL_CYCLES  = 200;
  localparam int PRED_DEPTH   = 8;

  logic          clk;
  logic          rst;
  logic          start;
  logic          busy;
  irsa_request_t request;
  logic          done;
  irsa_result_t  result;

  interval_resource_allocator_core #(
    .MAX_RES(NUM_RES)
  ) DUT (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .request(request),
    .done   (done),
    .result (result)
  );

  // Mirror of the allocator state.
  logic [TIME_BITS-1:0] until_m [NUM_RES];
  bit                   busy_m  [NUM_RES];
  logic [OUT_W-1:0]     free_m  [NUM_RES];
  int                   fifo_head_m;
  int                   fifo_count_m;
  int                   opened_m;

  // Predicted allocations, written at sent_count and read at checked_count.
  irsa_result_t pred_ring [PRED_DEPTH];

  int  errors;
  int  sent_count;
  int  checked_count;
  int  overflow_count;
  int  peak_releases;
  int  next_gap;
  bit  no_idle;
  bit  req_held;

  initial clk = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  function automatic irsa_result_t allocate_interval(irsa_request_t r);
    irsa_result_t     res;
    int               best;
    int               lim;
    int               rel;
    logic [OUT_W-1:0] id;
    bit               ovf;
    rel = 0;
    lim = (opened_m < NUM_RES) ? opened_m : NUM_RES;
    // Release one resource per pass, earliest busy-until first, lower id on ties.
    do begin
      best = -1;
      for (int i = 0; i < lim; i++) begin
        if (busy_m[i] && until_m[i] <= r.start_time &&
            (best < 0 || until_m[i] < until_m[best])) begin
          best = i;
        end
      end
      if (best >= 0) begin
        busy_m[best] = 1'b0;
        rel++;
        if (fifo_count_m < NUM_RES) begin
          free_m[(fifo_head_m + fifo_count_m) % NUM_RES] = OUT_W'(best + 1);
          fifo_count_m++;
        end
      end
    end while (best >= 0);
    if (rel > peak_releases) begin
      peak_releases = rel;
    end

    ovf = 1'b0;
    id  = '0;
    if (fifo_count_m > 0) begin
      id = free_m[fifo_head_m];
      fifo_head_m = (fifo_head_m + 1) % NUM_RES;
      fifo_count_m--;
    end else if (opened_m < NUM_RES) begin
      opened_m++;
      id = OUT_W'(opened_m);
    end else begin
      ovf = 1'b1;
    end

    if (!ovf && id >= 1 && id <= NUM_RES) begin
      until_m[id-1] = r.end_time;
      busy_m[id-1]  = 1'b1;
    end else begin
      id = '0;
    end

    res.resource_id    = id;
    res.resources_used = OUT_W'(opened_m);
    res.overflow       = ovf;
    return res;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle) begin
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 4);
    if (roll < 97) return $urandom_range(5, 30);
    return $urandom_range(50, 300);
  endfunction

  // Sends one request; start stays high across back-to-back requests.
  task automatic send_interval(input logic [TIME_BITS-1:0] s, input logic [TIME_BITS-1:0] e);
    irsa_request_t r;
    r.start_time = s;
    r.end_time   = e;
    if (next_gap > 0) begin
      repeat (next_gap) @(posedge clk);
    end
    start    <= 1'b1;
    request  <= r;
    req_held = 1'b1;
    do @(posedge clk); while (busy);
    pred_ring[sent_count % PRED_DEPTH] = allocate_interval(r);
    sent_count++;
    next_gap = pick_gap();
    if (next_gap > 0) begin
      start    <= 1'b0;
      req_held = 1'b0;
    end
  endtask

  // Holds off the sender until every predicted allocation has been checked.
  task automatic drain_results();
    if (req_held) begin
      start    <= 1'b0;
      req_held = 1'b0;
    end
    while (sent_count != checked_count) @(posedge clk);
    next_gap = 0;
  endtask

  always @(posedge clk) begin
    irsa_result_t want;
    if (!rst && done) begin
      if (sent_count == checked_count) begin
        report_mismatch("unexpected result, resource_id", result.resource_id, 0);
      end else begin
        want = pred_ring[checked_count % PRED_DEPTH];
        checked_count++;
        if (result.overflow) begin
          overflow_count++;
        end
        if (result.resource_id !== want.resource_id) begin
          report_mismatch("resource_id", result.resource_id, want.resource_id);
        end
        if (result.resources_used !== want.resources_used) begin
          report_mismatch("resources_used", result.resources_used, want.resources_used);
        end
        if (result.overflow !== want.overflow) begin
          report_mismatch("overflow", result.overflow, want.overflow);
        end
      end
    end
  end

  // Watchdog: cycles in which neither a request nor a result moves.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((start && !busy) || done || rst) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("FAIL interval_resource_allocator_core");
        $finish;
      end
    end
  end

  task automatic test_directed_corners();
    send_interval(16'd0, 16'd0);
    send_interval(16'd0, 16'd0);           // releases at exactly its end
    send_interval(16'd0, 16'hFFFF);
    send_interval(16'd1, 16'd2);           // opens a new resource
    send_interval(16'd2, 16'd2);
    send_interval(16'd100, 16'd50);        // end before start
    send_interval(16'd120, 16'd130);
    send_interval(16'd200, 16'd300);
    send_interval(16'd200, 16'd300);
    send_interval(16'd200, 16'd250);
    send_interval(16'd300, 16'd400);       // ties on busy-until go to lower id
    send_interval(16'd300, 16'd400);
    send_interval(16'd300, 16'd400);
    send_interval(16'd10, 16'd20);         // unsorted input
    send_interval(16'hAAAA, 16'h5555);
    send_interval(16'h5555, 16'hAAAA);
    send_interval(16'hFFFF, 16'hFFFF);
    send_interval(16'hFFFF, 16'd0);
    drain_results();
  endtask

  task automatic test_random_epochs();
    int cursor;
    int burst;
    int roll;
    int dur;
    logic [TIME_BITS-1:0] s;
    logic [TIME_BITS-1:0] e;
    cursor = $urandom_range(0, 300);
    burst  = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      roll = $urandom_range(0, 99);
      if (n % 300 == 299) begin
        drain_results();
        no_idle = ($urandom_range(0, 2) == 0);
      end
      if (burst == 0 && roll < 3) begin
        burst = $urandom_range(10, 40);
      end
      if (burst > 0) begin
        burst--;
      end else if (roll < 90) begin
        cursor += $urandom_range(0, 40);
      end else begin
        cursor += $urandom_range(41, 2000);
      end
      if (cursor > 65535) begin
        // End of an epoch: free everything, then start over near zero.
        send_interval(16'hFFFF, TIME_BITS'($urandom_range(0, 65535)));
        cursor = $urandom_range(0, 300);
        no_idle = ($urandom_range(0, 3) == 0);
        continue;
      end
      s    = TIME_BITS'(cursor);
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        // Noise: an arbitrary interval outside the sorted order.
        s = TIME_BITS'($urandom_range(0, 65535));
        e = TIME_BITS'($urandom_range(0, 65535));
      end else if (roll < 8) begin
        e = TIME_BITS'($urandom_range(0, cursor));
      end else begin
        dur = (roll < 88) ? $urandom_range(0, 150) : $urandom_range(151, 3000);
        e   = (cursor + dur > 65535) ? 16'hFFFF : TIME_BITS'(cursor + dur);
      end
      send_interval(s, e);
    end
    drain_results();
  endtask

  task automatic test_overflow_and_mass_release();
    no_idle = 1'b0;
    // Every resource stays busy until the top of time, so the table fills up.
    for (int n = 0; n < NUM_RES + 6; n++) begin
      send_interval(16'd0, 16'hFFFF);
    end
    drain_results();
    send_interval(16'hFFFF, 16'd0);         // releases every open resource
    send_interval(16'hFFFF, 16'hFFFF);
    send_interval(16'd0, 16'd1);
    drain_results();
  endtask

  initial begin
    errors         = 0;
    sent_count     = 0;
    checked_count  = 0;
    overflow_count = 0;
    peak_releases  = 0;
    next_gap       = 0;
    no_idle        = 1'b0;
    req_held       = 1'b0;
    for (int i = 0; i < NUM_RES; i++) begin
      until_m[i] = '0;
      busy_m[i]  = 1'b0;
      free_m[i]  = '0;
    end
    free_m[0]    = OUT_W'(1);
    fifo_head_m  = 0;
    fifo_count_m = 1;
    opened_m     = 1;

    rst     = 1'b1;
    start   = 1'b0;
    request = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_corners();
    test_random_epochs();
    test_overflow_and_mass_release();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sent_count != checked_count) begin
      report_mismatch("results still outstanding", 0, sent_count - checked_count);
    end

    $display("Sent %0d intervals and checked %0d allocations, %0d of them overflows.",
             sent_count, checked_count, overflow_count);
    $display("Largest release burst for one interval: %0d resources; %0d mismatches.",
             peak_releases, errors);
    if (errors == 0) begin
      $display("PASS interval_resource_allocator_core");
    end else begin
      $display("FAIL interval_resource_allocator_core");
    end
    $finish;
  end

endmodule

### files.f
rtl/irsa_pkg.sv
rtl/irsa_busy_table.sv
rtl/irsa_free_fifo.sv
rtl/irsa_ctrl.sv
rtl/interval_resource_allocator_core.sv
rtl/irsa_checker.sv
tb/tb_interval_resource_allocator_core.sv
